@@ design/icstd_pkg.sv @@
// ----------------------------------------------------------------------------
// icstd_pkg
// Shared types, event codes and register addresses for the color sensor
// transaction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package icstd_pkg;

	// Default depth of the captured byte store.
	localparam int BSTORE_DEPTH_DEFAULT = 8;

	// Bus address followed after reset.
	localparam logic [6:0] DEV_ADDR_RESET = 7'h29;

	// Bus event codes.
	localparam logic [3:0] EV_START = 4'd0;
	localparam logic [3:0] EV_AW    = 4'd1;
	localparam logic [3:0] EV_AR    = 4'd2;
	localparam logic [3:0] EV_ACK   = 4'd3;
	localparam logic [3:0] EV_NACK  = 4'd4;
	localparam logic [3:0] EV_DW    = 4'd5;
	localparam logic [3:0] EV_DR    = 4'd6;
	localparam logic [3:0] EV_STOP  = 4'd7;

	// Sensor register addresses and values.
	localparam logic [5:0] REG_ENABLE  = 6'h00;
	localparam logic [5:0] REG_PERS    = 6'h0C;
	localparam logic [5:0] REG_CONFIG  = 6'h0D;
	localparam logic [5:0] REG_CONTROL = 6'h0F;
	localparam logic [5:0] REG_ID      = 6'h12;
	localparam logic [5:0] REG_STATUS  = 6'h13;
	localparam logic [5:0] REG_CDATA   = 6'h14;
	localparam logic [5:0] REG_BDATAH  = 6'h1B;
	localparam logic [6:0] CMD_CLR_INT = 7'h66;
	localparam logic [7:0] ID_KIND_A   = 8'h44;
	localparam logic [7:0] ID_KIND_B   = 8'h4D;

	// Snapshot of the transaction taken when a stop completes it.
	typedef struct packed {
		logic [5:0] reg_num;
		logic [6:0] cmd_bits;
		logic [3:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
	} snap_t;

	// One decoded result.
	typedef struct packed {
		logic [5:0]  register_number;
		logic [3:0]  byte_count;
		logic [15:0] reg_value;
		logic        clear_interrupt;
		logic        known_register;
		logic [5:0]  persist_count;
		logic [3:0]  enable_bits;
		logic        wait_long;
		logic [1:0]  gain_code;
		logic [1:0]  status_bits;
		logic [1:0]  chip_kind;
		logic [2:0]  channel_kind;
	} result_t;

endpackage

`default_nettype wire

@@ design/icstd_tracker.sv @@
// ----------------------------------------------------------------------------
// icstd_tracker
// Follows the bus transaction phase by phase, holds the command byte and the
// captured data bytes, and flags the stop that completes a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module icstd_tracker
	import icstd_pkg::*;
#(
	parameter int BYTE_STORE_DEPTH = BSTORE_DEPTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [3:0] opcode,
	input  wire logic [7:0] data_byte,
	input  wire logic [6:0] dev_addr,
	output logic            done,
	output snap_t           snap
);

	localparam int CNT_W = $clog2(BYTE_STORE_DEPTH + 1);
	localparam int IDX_W = $clog2(BYTE_STORE_DEPTH);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_AW, PH_AW_ACK, PH_CMD, PH_WR_ACK,
		PH_WR, PH_AR, PH_AR_ACK, PH_RD, PH_RD_ACK
	} phase_t;

	phase_t           phase_q;
	phase_t           phase_nxt;
	logic [5:0]       reg_q;
	logic [6:0]       cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       store_q [BYTE_STORE_DEPTH];
	logic             cmd_load;
	logic             capture;
	logic [7:0]       cnt_ext;

	// Next phase, command load and byte capture for the current event.
	always_comb begin
		phase_nxt = PH_IDLE;
		cmd_load  = 1'b0;
		capture   = 1'b0;
		done      = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (opcode == EV_START) phase_nxt = PH_START;
			end
			PH_START: begin
				if (opcode == EV_AW && data_byte == {1'b0, dev_addr}) phase_nxt = PH_AW;
				else if (opcode == EV_AR && data_byte == {1'b0, dev_addr}) phase_nxt = PH_AR;
			end
			PH_AW: begin
				if (opcode == EV_ACK) phase_nxt = PH_AW_ACK;
			end
			PH_AW_ACK: begin
				if (opcode == EV_DW) begin
					cmd_load  = 1'b1;
					phase_nxt = PH_CMD;
				end
			end
			PH_CMD, PH_WR: begin
				if (opcode == EV_ACK) phase_nxt = PH_WR_ACK;
			end
			PH_WR_ACK: begin
				if (opcode == EV_DW) begin
					capture   = 1'b1;
					phase_nxt = PH_WR;
				end else if (opcode == EV_STOP) begin
					done = 1'b1;
				end
			end
			PH_AR: begin
				if (opcode == EV_ACK) phase_nxt = PH_AR_ACK;
			end
			PH_AR_ACK: begin
				if (opcode == EV_DR) begin
					capture   = 1'b1;
					phase_nxt = PH_RD;
				end
			end
			PH_RD: begin
				if (opcode == EV_ACK) phase_nxt = PH_RD_ACK;
				else if (opcode == EV_NACK) phase_nxt = PH_RD;
				else if (opcode == EV_STOP) done = 1'b1;
				else if (opcode == EV_DR) begin
					capture   = 1'b1;
					phase_nxt = PH_RD;
				end
			end
			PH_RD_ACK: begin
				if (opcode == EV_STOP) done = 1'b1;
				else if (opcode == EV_DR) begin
					capture   = 1'b1;
					phase_nxt = PH_RD;
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase
	end

	// Phase, command and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			reg_q   <= '0;
			cmd_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if (cmd_load) begin
				reg_q <= data_byte[5:0];
				cmd_q <= data_byte[6:0];
				cnt_q <= '0;
			end else if (done) begin
				cnt_q <= '0;
			end else if (capture && cnt_q < CNT_W'(BYTE_STORE_DEPTH)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Byte store; bytes past the last entry are dropped.
	always_ff @(posedge clk) begin
		if (accept && capture && cnt_q < CNT_W'(BYTE_STORE_DEPTH)) begin
			store_q[cnt_q[IDX_W-1:0]] <= data_byte;
		end
	end

	// Snapshot handed to the field decoder.
	assign cnt_ext       = {{(8 - CNT_W){1'b0}}, cnt_q};
	assign snap.reg_num  = reg_q;
	assign snap.cmd_bits = cmd_q;
	assign snap.count    = (cnt_ext > 8'd15) ? 4'd15 : cnt_ext[3:0];
	assign snap.b0       = (cnt_q >= CNT_W'(1)) ? store_q[0] : 8'h00;
	assign snap.b1       = (cnt_q >= CNT_W'(2)) ? store_q[1] : 8'h00;

endmodule

`default_nettype wire

@@ design/icstd_field_decode.sv @@
// ----------------------------------------------------------------------------
// icstd_field_decode
// Turns a transaction snapshot into the value and decoded register fields.
// ----------------------------------------------------------------------------
`default_nettype none

module icstd_field_decode
	import icstd_pkg::*;
(
	input  snap_t   snap,
	output result_t res
);

	logic [5:0] r;
	logic [7:0] b0;
	logic       has_data;
	logic [3:0] pnib;
	logic [5:0] pbase;
	logic [5:0] cidx;

	assign r        = snap.reg_num;
	assign b0       = snap.b0;
	assign has_data = (snap.count != 4'd0);
	assign pnib     = b0[3:0];
	assign pbase    = {2'b00, pnib} - 6'd3;
	assign cidx     = r - REG_CDATA;

	// Common fields and the one decoded field that the register selects.
	always_comb begin
		res                 = '0;
		res.register_number = r;
		res.byte_count      = snap.count;
		if (snap.count == 4'd1) res.reg_value = {8'h00, b0};
		else if (snap.count != 4'd0) res.reg_value = {snap.b1, b0};
		res.clear_interrupt = !has_data && (snap.cmd_bits == CMD_CLR_INT);
		res.known_register  = (r <= 6'h01) || (r >= 6'h03 && r <= 6'h07) ||
			(r == REG_PERS) || (r == REG_CONFIG) || (r == REG_CONTROL) ||
			(r >= REG_ID && r <= REG_BDATAH);
		if (has_data) begin
			if (r == REG_PERS) begin
				res.persist_count = (pnib > 4'd3) ? ({pbase[3:0], 2'b00} + pbase) :
					{2'b00, pnib};
			end else if (r == REG_ENABLE) begin
				res.enable_bits = {b0[4], b0[3], b0[1], b0[0]};
			end else if (r == REG_CONFIG) begin
				res.wait_long = b0[1];
			end else if (r == REG_CONTROL) begin
				res.gain_code = b0[1:0];
			end else if (r == REG_STATUS) begin
				res.status_bits = {b0[4], b0[0]};
			end else if (r == REG_ID) begin
				if (b0 == ID_KIND_A) res.chip_kind = 2'd1;
				else if (b0 == ID_KIND_B) res.chip_kind = 2'd2;
			end else if (r >= REG_CDATA && r <= REG_BDATAH) begin
				res.channel_kind = cidx[3:1] + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/i2c_color_sensor_transaction_decoder.sv @@
// Output: a result appears in the cycle after the stop transfer that completes it.
// Throughput: one event per cycle; the event path only stalls while a finished
// result is held in the output register and the output side stalls.
// Reset: asynchronous, active low; the phase returns to idle, counters and
// command bits clear, and the followed address returns to 0x29.
// ----------------------------------------------------------------------------
// i2c_color_sensor_transaction_decoder
// Follows bus transactions to a color light sensor and reports each completed
// register access with its decoded fields.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_color_sensor_transaction_decoder
	import icstd_pkg::*;
#(
	parameter int BYTE_STORE_DEPTH = BSTORE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  opcode,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       register_number,
	output logic [3:0]       byte_count,
	output logic [15:0]      reg_value,
	output logic             clear_interrupt,
	output logic             known_register,
	output logic [5:0]       persist_count,
	output logic [3:0]       enable_bits,
	output logic             wait_long,
	output logic [1:0]       gain_code,
	output logic [1:0]       status_bits,
	output logic [1:0]       chip_kind,
	output logic [2:0]       channel_kind
);

	logic [6:0] addr_q;
	logic       accept;
	logic       done;
	snap_t      snap;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;

	// Followed bus address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= DEV_ADDR_RESET;
		end else if (cfg_write) begin
			addr_q <= cfg_data;
		end
	end

	// Events are taken unless a held result is blocked downstream.
	assign in_stall   = out_valid_q && out_stall;
	assign accept     = in_valid && !in_stall;

	icstd_tracker #(
		.BYTE_STORE_DEPTH(BYTE_STORE_DEPTH)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (opcode),
		.data_byte(data_byte),
		.dev_addr (addr_q),
		.done     (done),
		.snap     (snap)
	);

	icstd_field_decode u_decode (
		.snap(snap),
		.res (res)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept && done) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign register_number = res_q.register_number;
	assign byte_count      = res_q.byte_count;
	assign reg_value       = res_q.reg_value;
	assign clear_interrupt = res_q.clear_interrupt;
	assign known_register  = res_q.known_register;
	assign persist_count   = res_q.persist_count;
	assign enable_bits     = res_q.enable_bits;
	assign wait_long       = res_q.wait_long;
	assign gain_code       = res_q.gain_code;
	assign status_bits     = res_q.status_bits;
	assign chip_kind       = res_q.chip_kind;
	assign channel_kind    = res_q.channel_kind;

endmodule

`default_nettype wire
